// File: sv/stns_pkg.sv
// ============================================================================
// Sorted table nearest search: shared definitions
// Codes, controller states and the command/status bundles between the
// controller and the datapath.
// ============================================================================
package stns_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int INDEX_W         = 8;
   localparam int COUNT_W         = 9;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_FIRST,
      ST_CHK_LAST,
      ST_CHK_MID,
      ST_CHK_BELOW,
      ST_CHK_ABOVE
   } state_type;

   typedef enum logic [2:0] {
      RD_FIRST,
      RD_LAST,
      RD_MID,
      RD_BELOW,
      RD_ABOVE
   } rd_sel_type;

   typedef enum logic [1:0] {
      BND_HOLD,
      BND_INIT,
      BND_LOWER,
      BND_UPPER
   } bnd_op_type;

   typedef enum logic [1:0] {
      RES_DATA,
      RES_PROBE,
      RES_NEAR_BELOW,
      RES_NEAR_ABOVE
   } res_sel_type;

   typedef struct packed {
      logic        wr_en;
      logic        load;
      logic        rd_en;
      rd_sel_type  rd_sel;
      bnd_op_type  bnd_op;
      logic        probe_ld;
      logic        res_ld;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic t_lt;
      logic t_eq;
      logic mid_zero;
      logic mid_top;
      logic open_lower;
      logic open_upper;
   } status_type;

endpackage

// File: sv/stns_ctrl.sv
// ============================================================================
// Sorted table nearest search: controller
// Sequences boundary checks and the binary search probes, owns the
// response valid flag.
// ============================================================================
module stns_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  stns_pkg::status_type status,
   output stns_pkg::cmd_type    cmd
);
   import stns_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      t_gt;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign t_gt     = !status.t_lt && !status.t_eq;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_opcode == OP_QUERY) begin
               state_in = ST_CHK_FIRST;
            end
         end
         ST_CHK_FIRST: begin
            if (out_free) begin
               state_in = (status.t_lt || status.t_eq) ? ST_IDLE : ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            if (out_free) begin
               state_in = status.t_lt ? ST_CHK_MID : ST_IDLE;
            end
         end
         ST_CHK_MID: begin
            if (out_free) begin
               if (status.t_eq) begin
                  state_in = ST_IDLE;
               end else if (status.t_lt) begin
                  if (!status.mid_zero) state_in = ST_CHK_BELOW;
                  else state_in = status.open_lower ? ST_CHK_MID : ST_IDLE;
               end else begin
                  if (!status.mid_top) state_in = ST_CHK_ABOVE;
                  else state_in = status.open_upper ? ST_CHK_MID : ST_IDLE;
               end
            end
         end
         ST_CHK_BELOW: begin
            if (out_free) begin
               if (t_gt) state_in = ST_IDLE;
               else state_in = status.open_lower ? ST_CHK_MID : ST_IDLE;
            end
         end
         ST_CHK_ABOVE: begin
            if (out_free) begin
               if (status.t_lt) state_in = ST_IDLE;
               else state_in = status.open_upper ? ST_CHK_MID : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.load   = 1'b1;
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_FIRST;
               end
            end
         end
         ST_CHK_FIRST: begin
            if (out_free) begin
               if (status.t_lt || status.t_eq) begin
                  cmd.res_ld  = 1'b1;
                  cmd.res_sel = RES_DATA;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_LAST;
               end
            end
         end
         ST_CHK_LAST: begin
            if (out_free) begin
               if (!status.t_lt) begin
                  cmd.res_ld  = 1'b1;
                  cmd.res_sel = RES_DATA;
               end else begin
                  cmd.bnd_op = BND_INIT;
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_MID;
               end
            end
         end
         ST_CHK_MID: begin
            if (out_free) begin
               cmd.probe_ld = 1'b1;
               if (status.t_eq) begin
                  cmd.res_ld  = 1'b1;
                  cmd.res_sel = RES_DATA;
               end else if (status.t_lt) begin
                  if (!status.mid_zero) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_BELOW;
                  end else begin
                     cmd.bnd_op = BND_LOWER;
                     if (status.open_lower) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_MID;
                     end else begin
                        cmd.res_ld  = 1'b1;
                        cmd.res_sel = RES_DATA;
                     end
                  end
               end else begin
                  if (!status.mid_top) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ABOVE;
                  end else begin
                     cmd.bnd_op = BND_UPPER;
                     if (status.open_upper) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_MID;
                     end else begin
                        cmd.res_ld  = 1'b1;
                        cmd.res_sel = RES_DATA;
                     end
                  end
               end
            end
         end
         ST_CHK_BELOW: begin
            if (out_free) begin
               if (t_gt) begin
                  cmd.res_ld  = 1'b1;
                  cmd.res_sel = RES_NEAR_BELOW;
               end else begin
                  cmd.bnd_op = BND_LOWER;
                  if (status.open_lower) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_MID;
                  end else begin
                     cmd.res_ld  = 1'b1;
                     cmd.res_sel = RES_PROBE;
                  end
               end
            end
         end
         ST_CHK_ABOVE: begin
            if (out_free) begin
               if (status.t_lt) begin
                  cmd.res_ld  = 1'b1;
                  cmd.res_sel = RES_NEAR_ABOVE;
               end else begin
                  cmd.bnd_op = BND_UPPER;
                  if (status.open_upper) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_MID;
                  end else begin
                     cmd.res_ld  = 1'b1;
                     cmd.res_sel = RES_PROBE;
                  end
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_ld) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == OP_QUERY) |=> state_ff == ST_CHK_FIRST)
      else $error("query transaction did not start the search");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.res_ld |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending response");

   a_result_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) != ST_IDLE)
      else $error("response raised outside a search");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (!cmd.wr_en && !cmd.load))
      else $error("request taken during a search");

endmodule

// File: sv/stns_dpath.sv
// ============================================================================
// Sorted table nearest search: datapath
// Table memory, count register, search bounds, comparators and the
// nearest-neighbor pick.
// ============================================================================
module stns_dpath #(
   parameter int TABLE_DEPTH = stns_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = stns_pkg::DEF_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic        [stns_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic        [stns_pkg::INDEX_W-1:0] req_entry_index,
   input  logic signed [VALUE_WIDTH-1:0]     req_value,
   input  stns_pkg::cmd_type                 cmd,
   output stns_pkg::status_type              status,
   output logic signed [VALUE_WIDTH-1:0]     rsp_nearest_value
);
   import stns_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

   logic        [COUNT_W-1:0]     count_ff;
   logic        [CNT_W-1:0]       n_ff, n_in;
   logic signed [VALUE_WIDTH-1:0] target_ff;
   logic        [CNT_W-1:0]       left_ff, left_in;
   logic        [CNT_W-1:0]       right_ff, right_in;
   logic        [IDX_W-1:0]       mid_ff, mid_in;
   logic        [CNT_W:0]         mid_sum;
   logic        [CNT_W-1:0]       mid_ext;
   logic signed [VALUE_WIDTH-1:0] probe_ff;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic signed [VALUE_WIDTH-1:0] result_ff, result_in;
   logic        [IDX_W-1:0]       rd_addr;
   logic                          wr_hit;
   logic signed [VALUE_WIDTH-1:0] near_lo, near_hi;
   logic        [VALUE_WIDTH-1:0] dist_lo, dist_hi;

   // count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         n_in = CNT_W'(1);
      end else if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         n_in = CNT_W'(TABLE_DEPTH);
      end else begin
         n_in = CNT_W'(count_ff);
      end
   end

   assign mid_ext = CNT_W'(mid_ff);

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      case (cmd.bnd_op)
         BND_INIT: begin
            left_in  = '0;
            right_in = n_ff;
         end
         BND_LOWER: right_in = mid_ext;
         BND_UPPER: left_in  = mid_ext + CNT_W'(1);
         default: ;
      endcase
   end

   assign mid_sum = (CNT_W+1)'(left_in) + (CNT_W+1)'(right_in);
   assign mid_in  = IDX_W'(mid_sum >> 1);

   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = IDX_W'(n_ff - CNT_W'(1));
         RD_MID:   rd_addr = mid_in;
         RD_BELOW: rd_addr = mid_ff - IDX_W'(1);
         RD_ABOVE: rd_addr = mid_ff + IDX_W'(1);
         default:  rd_addr = '0;
      endcase
   end

   assign wr_hit = cmd.wr_en && (32'(req_entry_index) < 32'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[IDX_W'(req_entry_index)] <= req_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= req_value;
         n_ff      <= n_in;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
      if (cmd.rd_en && cmd.rd_sel == RD_MID) begin
         mid_ff <= mid_in;
      end
      if (cmd.probe_ld) begin
         probe_ff <= rd_data_ff;
      end
      if (cmd.res_ld) begin
         result_ff <= result_in;
      end
   end

   // lo < target < hi here, so both distances are non-negative
   assign near_lo = (cmd.res_sel == RES_NEAR_BELOW) ? rd_data_ff : probe_ff;
   assign near_hi = (cmd.res_sel == RES_NEAR_BELOW) ? probe_ff : rd_data_ff;
   assign dist_lo = target_ff - near_lo;
   assign dist_hi = near_hi - target_ff;

   always_comb begin
      case (cmd.res_sel)
         RES_DATA:  result_in = rd_data_ff;
         RES_PROBE: result_in = probe_ff;
         RES_NEAR_BELOW, RES_NEAR_ABOVE:
            result_in = (dist_lo >= dist_hi) ? near_hi : near_lo;
         default:   result_in = rd_data_ff;
      endcase
   end

   assign status.t_lt       = target_ff < rd_data_ff;
   assign status.t_eq       = target_ff == rd_data_ff;
   assign status.mid_zero   = mid_ff == '0;
   assign status.mid_top    = (mid_ext + CNT_W'(1)) >= n_ff;
   assign status.open_lower = left_ff < mid_ext;
   assign status.open_upper = (mid_ext + CNT_W'(1)) < right_ff;

   assign rsp_nearest_value = result_ff;

   a_count_clamped: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (n_ff != '0) && (32'(n_ff) <= 32'(TABLE_DEPTH)))
      else $error("element count out of range");

   a_mid_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.rd_sel == RD_MID) |=> (mid_ext >= left_ff) && (mid_ext < right_ff))
      else $error("probe index outside search bounds");

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      (cmd.bnd_op != BND_HOLD) |=> (left_ff <= right_ff) && (right_ff <= n_ff))
      else $error("search bounds crossed");

endmodule

// File: sv/sorted_table_nearest_search.sv
// ============================================================================
// Sorted table nearest search
// Table of ascending signed fixed-point entries with a binary search that
// returns the entry nearest a target (ties go to the upper neighbor).
//
//   Channel  Ports                                        Direction
//   req      req_valid/ready, opcode, entry_index, value  in
//   rsp      rsp_valid/ready, nearest_value               out
//   csr      csr_wr_en, csr_wr_data (element_count)       in
//
// A write transaction is taken while idle; writes can follow back to back.
// A query checks the first and last entries, then runs binary search probes
// with neighbor checks, one at a time on the single table read port.
// One query in flight; the response register lets the next request in.
// A pending response stalls the search until it is taken.
// Synchronous reset sets element_count to 1; table contents stay unknown.
// ============================================================================
module sorted_table_nearest_search #(
   parameter int TABLE_DEPTH = stns_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = stns_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic        [stns_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic        [stns_pkg::INDEX_W-1:0] req_entry_index,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]       rsp_nearest_value
);
   import stns_pkg::*;

   cmd_type    cmd;
   status_type status;

   stns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   stns_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_entry_index   (req_entry_index),
      .req_value         (req_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_nearest_value (rsp_nearest_value)
   );

endmodule

// File: tb/tb_sorted_table_nearest_search.sv
// ============================================================================
// Sorted table nearest search: testbench
// Drives table writes and nearest-value queries over the req channel, steps
// element_count through its range between bursts, and checks every rsp
// transaction against a listed value or an in-bench copy of the table and
// its search. A short directed table comes first, then random sorted fills,
// queries around the stored entries and stray writes, under several sender
// and receiver idle and stall mixes.
// ============================================================================
module tb_sorted_table_nearest_search;
   import stns_pkg::*;

   localparam int DEPTH        = DEF_TABLE_DEPTH;
   localparam int VW           = DEF_VALUE_WIDTH;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE       = 25;
   localparam int RANDOM_ITEMS = 400;

   localparam int SEND_IDLE [4] = '{0, 48, 0, 19};
   localparam int RECV_STALL[4] = '{0, 0, 48, 19};

   typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   idx;
      logic [31:0]  val;
      logic         typed;
      logic [31:0]  want;
   } stim_row_type;

   localparam stim_row_type DIRECTED [26] = '{
      '{ROW_WRITE, 8'h00, 32'h0001_0000, 1'b0, 32'h0},
      '{ROW_QUERY, 8'hFF, 32'h8000_0000, 1'b1, 32'h0001_0000},
      '{ROW_QUERY, 8'h00, 32'h7FFF_FFFF, 1'b1, 32'h0001_0000},
      '{ROW_QUERY, 8'hA5, 32'h0001_0000, 1'b1, 32'h0001_0000},
      '{ROW_CFG,   8'h00, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_QUERY, 8'h5A, 32'h0000_0000, 1'b1, 32'h0001_0000},
      '{ROW_WRITE, 8'h00, 32'h8000_0000, 1'b0, 32'h0},
      '{ROW_WRITE, 8'h01, 32'hFFFF_0000, 1'b0, 32'h0},
      '{ROW_WRITE, 8'h02, 32'h0001_0000, 1'b0, 32'h0},
      '{ROW_WRITE, 8'h03, 32'h0003_0000, 1'b0, 32'h0},
      '{ROW_WRITE, 8'h04, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_CFG,   8'h00, 32'h0000_0005, 1'b0, 32'h0},
      '{ROW_QUERY, 8'h00, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_QUERY, 8'h00, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_QUERY, 8'h00, 32'h0000_0000, 1'b1, 32'h0001_0000},
      '{ROW_QUERY, 8'h00, 32'h0002_0000, 1'b1, 32'h0003_0000},
      '{ROW_QUERY, 8'h00, 32'h0001_FFFF, 1'b1, 32'h0001_0000},
      '{ROW_QUERY, 8'h00, 32'h0002_0001, 1'b1, 32'h0003_0000},
      '{ROW_QUERY, 8'h00, 32'hFFFF_0000, 1'b1, 32'hFFFF_0000},
      '{ROW_QUERY, 8'h00, 32'hC000_0000, 1'b0, 32'h0},
      // entry 3 below entry 2: table no longer sorted
      '{ROW_WRITE, 8'h03, 32'hFFFE_0000, 1'b0, 32'h0},
      '{ROW_QUERY, 8'h00, 32'h0002_0000, 1'b0, 32'h0},
      '{ROW_QUERY, 8'h00, 32'hFFFF_8000, 1'b0, 32'h0},
      '{ROW_CFG,   8'h00, 32'h0000_0003, 1'b0, 32'h0},
      '{ROW_QUERY, 8'h00, 32'h0000_8000, 1'b0, 32'h0},
      '{ROW_QUERY, 8'h00, 32'h7FFF_FFFF, 1'b1, 32'h0001_0000}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]   csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_opcode = OP_WRITE;
   logic [INDEX_W-1:0]   req_entry_index = '0;
   logic signed [VW-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [VW-1:0] rsp_nearest_value;

   logic signed [VW-1:0] entry_copy [0:DEPTH-1];
   bit                   entry_written [0:DEPTH-1];
   logic [COUNT_W-1:0]   count_copy = COUNT_RESET;
   logic signed [VW-1:0] nearest_due [$];
   logic signed [VW-1:0] due_value;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   sorted_table_nearest_search #(
      .TABLE_DEPTH(DEPTH),
      .VALUE_WIDTH(VW)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_value (rsp_nearest_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int live_entries();
      if (count_copy == 0) return 1;
      if (count_copy > DEPTH) return DEPTH;
      return int'(count_copy);
   endfunction

   // lo < t < hi; tie goes to hi
   function automatic logic signed [VW-1:0] nearer_of(input logic signed [VW-1:0] lo,
                                                      input logic signed [VW-1:0] hi,
                                                      input logic signed [VW-1:0] t);
      longint d_lo;
      longint d_hi;
      d_lo = longint'(t) - longint'(lo);
      d_hi = longint'(hi) - longint'(t);
      return (d_lo >= d_hi) ? hi : lo;
   endfunction

   function automatic logic signed [VW-1:0] nearest_entry(input logic signed [VW-1:0] t);
      int n;
      int left;
      int right;
      int mid;
      logic signed [VW-1:0] probe;
      n = live_entries();
      if (t <= entry_copy[0]) return entry_copy[0];
      if (t >= entry_copy[n-1]) return entry_copy[n-1];
      left  = 0;
      right = n;
      mid   = 0;
      while (left < right) begin
         mid   = (left + right) / 2;
         probe = entry_copy[mid];
         if (probe == t) return probe;
         if (t < probe) begin
            if (mid > 0 && t > entry_copy[mid-1])
               return nearer_of(entry_copy[mid-1], probe, t);
            right = mid;
         end else begin
            if (mid + 1 < n && t < entry_copy[mid+1])
               return nearer_of(probe, entry_copy[mid+1], t);
            left = mid + 1;
         end
      end
      return entry_copy[mid];
   endfunction

   function automatic bit table_ready(input int n);
      for (int i = 0; i < n; i++)
         if (!entry_written[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic signed [VW-1:0] pick_target(input int n);
      int     r;
      int     i;
      longint a;
      longint b;
      r = $urandom_range(0, 99);
      i = $urandom_range(0, n - 1);
      if (r < 35)
         return entry_copy[i] + (int'($urandom_range(0, 6)) - 3);
      if (r < 55 && i + 1 < n) begin
         a = entry_copy[i];
         b = entry_copy[i+1];
         return VW'(((a + b) >>> 1) + longint'($urandom_range(0, 1)));
      end
      if (r < 70) return $urandom;
      if (r < 78) return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return entry_copy[i];
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                            input logic signed [VW-1:0] val,
                            input bit typed = 1'b0,
                            input logic signed [VW-1:0] want = '0);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_value       <= val;
      do @(posedge clock); while (!req_ready);
      if (op == OP_WRITE) begin
         entry_copy[idx]    = val;
         entry_written[idx] = 1'b1;
      end else begin
         nearest_due.push_back(typed ? want : nearest_entry(val));
      end
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (nearest_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_count(input logic [COUNT_W-1:0] c);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      count_copy   = c;
   endtask

   task automatic fill_sorted(input int n);
      int     mode;
      longint step_max;
      longint v;
      mode = $urandom_range(0, 2);
      if (mode == 0) step_max = 3;
      else if (mode == 1) step_max = 64'h2_0000;
      else step_max = 64'h1_0000_0000 / n;
      if (step_max > 64'hFFFF_FFFF) step_max = 64'hFFFF_FFFF;
      if (mode == 2) begin
         v = -64'sd2147483648 + longint'($urandom_range(0, 32'(step_max)));
      end else begin
         v = longint'($signed($urandom));
         if (v + step_max * n > 64'sd2147483647) v = 64'sd2147483647 - step_max * n;
      end
      for (int i = 0; i < n; i++) begin
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         send_item(OP_WRITE, INDEX_W'(i), VW'(v));
         v += longint'($urandom_range(0, 32'(step_max)));
      end
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (nearest_due.size() == 0) begin
            log_error($sformatf("unexpected transaction: nearest_value %h", rsp_nearest_value));
         end else begin
            due_value = nearest_due.pop_front();
            if (rsp_nearest_value !== due_value)
               log_error($sformatf("nearest_value mismatch: expected %h got %h",
                                   due_value, rsp_nearest_value));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_table_nearest_search test failed");
         $finish;
      end
   end

   initial begin
      int r;
      int n;
      int phase_items;
      logic [COUNT_W-1:0] new_count;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         case (DIRECTED[i].kind)
            ROW_CFG: begin
               set_count(DIRECTED[i].val[COUNT_W-1:0]);
            end
            ROW_WRITE: begin
               send_item(OP_WRITE, DIRECTED[i].idx, DIRECTED[i].val);
            end
            default: begin
               send_item(OP_QUERY, DIRECTED[i].idx, DIRECTED[i].val,
                         DIRECTED[i].typed, DIRECTED[i].want);
            end
         endcase
      end

      for (int p = 0; p < 4; p++) begin
         wait_idle();
         send_idle_pct = SEND_IDLE[p];
         stall_pct     = RECV_STALL[p];
         phase_items   = 0;
         while (phase_items < RANDOM_ITEMS / 4) begin
            r = $urandom_range(0, 99);
            if (p == 0 && phase_items == 0) new_count = COUNT_W'(DEPTH);
            else if (r < 55) new_count = COUNT_W'($urandom_range(1, 8));
            else if (r < 75) new_count = COUNT_W'($urandom_range(9, 40));
            else if (r < 82) new_count = COUNT_W'(DEPTH);
            else if (r < 88) new_count = COUNT_W'($urandom_range(DEPTH + 1, 511));
            else if (r < 92) new_count = '1;
            else if (r < 96) new_count = '0;
            else new_count = COUNT_W'($urandom_range(41, DEPTH - 1));
            set_count(new_count);
            n = live_entries();
            if (!table_ready(n) || $urandom_range(0, 99) < ((n <= 40) ? 70 : 8)) begin
               fill_sorted(n);
               phase_items += n;
            end
            repeat ($urandom_range(4, 16)) begin
               // stray writes may break the ordering; the search must still agree
               if ($urandom_range(0, 99) < 15)
                  send_item(OP_WRITE, INDEX_W'($urandom_range(0, DEPTH - 1)), $urandom);
               else
                  send_item(OP_QUERY, INDEX_W'($urandom_range(0, DEPTH - 1)), pick_target(n));
               phase_items++;
            end
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("sorted_table_nearest_search test passed");
      end else begin
         $display("sorted_table_nearest_search test failed");
      end
      $finish;
   end

endmodule
